>>> rtl/core/ukt_pkg.sv
package ukt_pkg;

   // Default table depth
   localparam int CAPACITY_DEF = 16;

   // Field widths
   localparam int KEY_W    = 32;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 3;
   localparam int TOTAL_W  = 5;
   localparam int ENTRY_W  = KEY_W + VALUE_W;

   // Request kinds
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

   // Controller to datapath commands
   typedef struct packed {
      logic load;    // capture request, restart walk at entry zero
      logic walk;    // issue next read, consume returned entry
      logic shift;   // walk moves entries down instead of comparing
      logic rewind;  // restart walk just above the selected entry
      logic commit;  // update table and register the result
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic walk_done;  // all reads issued and consumed
      logic empty;      // no entries held
      logic remove;     // captured request is a removal
   } stat_type;

endpackage

>>> rtl/core/unique_key_table_delete_min.sv
// Key/value table with unique-key insert and delete-minimum.
//
// Request channel: drive req_kind, req_key and req_value with start high;
// the transfer happens at a rising edge where start is high and busy is
// low. Insert appends unless the key is already held (duplicate) or the
// table is full; remove takes out the earliest entry with the smallest
// signed value and closes the gap, keeping insertion order.
//
// Result channel: rsp_strobe is high for exactly one cycle per request,
// with rsp_status, rsp_removed_key, rsp_removed_value and rsp_entry_total
// valid in that cycle. The receiver cannot stall; each result must be
// taken in the cycle it is shown.
//
// With N entries held, an insert walks all N entries through the single
// read port of the entry store before the strobe. A removal walks the
// table once to find the minimum and again from the slot after the chosen
// one to shift later entries down. One request is in work at a time; busy
// is high meanwhile.
//
// Reset empties the table and drops any request in work; no clearing pass.
module unique_key_table_delete_min #(
   parameter int CAPACITY = ukt_pkg::CAPACITY_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_kind,
   input  logic signed [ukt_pkg::KEY_W-1:0]   req_key,
   input  logic signed [ukt_pkg::VALUE_W-1:0] req_value,
   output logic                               rsp_strobe,
   output logic [ukt_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [ukt_pkg::KEY_W-1:0]   rsp_removed_key,
   output logic signed [ukt_pkg::VALUE_W-1:0] rsp_removed_value,
   output logic [ukt_pkg::TOTAL_W-1:0]        rsp_entry_total
);

   ukt_pkg::cmd_type  cmd;
   ukt_pkg::stat_type stat;

   // Sequencer
   ukt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // Entry store, scan and result registers
   ukt_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_kind          (req_kind),
      .req_key           (req_key),
      .req_value         (req_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_removed_key   (rsp_removed_key),
      .rsp_removed_value (rsp_removed_value),
      .rsp_entry_total   (rsp_entry_total)
   );

endmodule

>>> rtl/core/ukt_ctrl.sv
module ukt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ukt_pkg::stat_type stat,
   output ukt_pkg::cmd_type  cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_SHIFT  = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.walk_done) begin
               if (stat.remove && !stat.empty) begin
                  cmd.rewind = 1'b1;
                  state_in   = S_SHIFT;
               end else begin
                  state_in = S_FINISH;
               end
            end else begin
               cmd.walk = 1'b1;
            end
         end
         S_SHIFT: begin
            if (stat.walk_done) begin
               state_in = S_FINISH;
            end else begin
               cmd.walk  = 1'b1;
               cmd.shift = 1'b1;
            end
         end
         S_FINISH: begin
            cmd.commit = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   // Checks
   a_accept_scans: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == S_SCAN))
      else $error("accepted request did not enter scan");

   a_finish_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) |=> (state_ff == S_IDLE))
      else $error("finish state held more than one cycle");

   a_shift_is_removal: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> stat.remove)
      else $error("shift pass on a request that is not a removal");

endmodule

>>> rtl/core/ukt_datapath.sv
module ukt_datapath #(
   parameter int CAPACITY = ukt_pkg::CAPACITY_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ukt_pkg::cmd_type                   cmd,
   output ukt_pkg::stat_type                  stat,
   input  logic                               req_kind,
   input  logic signed [ukt_pkg::KEY_W-1:0]   req_key,
   input  logic signed [ukt_pkg::VALUE_W-1:0] req_value,
   output logic                               rsp_strobe,
   output logic [ukt_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [ukt_pkg::KEY_W-1:0]   rsp_removed_key,
   output logic signed [ukt_pkg::VALUE_W-1:0] rsp_removed_value,
   output logic [ukt_pkg::TOTAL_W-1:0]        rsp_entry_total
);

   localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CntW = $clog2(CAPACITY + 1);

   // Entry store: key in the upper half, value in the lower half
   logic [ukt_pkg::ENTRY_W-1:0] entry_ff [CAPACITY];
   logic [ukt_pkg::ENTRY_W-1:0] rd_data_ff;

   logic                        rd_en;
   logic [IdxW-1:0]             rd_addr;
   logic                        wr_en;
   logic [IdxW-1:0]             wr_addr;
   logic [ukt_pkg::ENTRY_W-1:0] wr_data;

   // Table and walk control
   logic [CntW-1:0] fill_ff,     fill_in;
   logic [CntW-1:0] rd_ptr_ff,   rd_ptr_in;
   logic            pend_ff,     pend_in;
   logic [IdxW-1:0] pend_idx_ff, pend_idx_in;
   logic            dup_ff,      dup_in;

   // Current minimum
   logic [IdxW-1:0]                    best_idx_ff,   best_idx_in;
   logic signed [ukt_pkg::KEY_W-1:0]   best_key_ff,   best_key_in;
   logic signed [ukt_pkg::VALUE_W-1:0] best_value_ff, best_value_in;

   // Captured request
   logic                               req_kind_ff,  req_kind_in;
   logic signed [ukt_pkg::KEY_W-1:0]   req_key_ff,   req_key_in;
   logic signed [ukt_pkg::VALUE_W-1:0] req_value_ff, req_value_in;

   // Result registers
   logic                               rsp_valid_ff,  rsp_valid_in;
   logic [ukt_pkg::STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic signed [ukt_pkg::KEY_W-1:0]   rsp_key_ff,    rsp_key_in;
   logic signed [ukt_pkg::VALUE_W-1:0] rsp_value_ff,  rsp_value_in;
   logic [ukt_pkg::TOTAL_W-1:0]        rsp_total_ff,  rsp_total_in;

   logic signed [ukt_pkg::KEY_W-1:0]   rd_key;
   logic signed [ukt_pkg::VALUE_W-1:0] rd_value;

   assign rd_key   = rd_data_ff[ukt_pkg::ENTRY_W-1:ukt_pkg::VALUE_W];
   assign rd_value = rd_data_ff[ukt_pkg::VALUE_W-1:0];

   // Walk, compare, shift and commit
   always_comb begin
      fill_in       = fill_ff;
      rd_ptr_in     = rd_ptr_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      dup_in        = dup_ff;
      best_idx_in   = best_idx_ff;
      best_key_in   = best_key_ff;
      best_value_in = best_value_ff;
      req_kind_in   = req_kind_ff;
      req_key_in    = req_key_ff;
      req_value_in  = req_value_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_total_in  = rsp_total_ff;
      rd_en         = 1'b0;
      rd_addr       = rd_ptr_ff[IdxW-1:0];
      wr_en         = 1'b0;
      wr_addr       = pend_idx_ff - IdxW'(1);
      wr_data       = rd_data_ff;

      if (cmd.load) begin
         req_kind_in  = req_kind;
         req_key_in   = req_key;
         req_value_in = req_value;
         rd_ptr_in    = '0;
         pend_in      = 1'b0;
         dup_in       = 1'b0;
      end

      if (cmd.rewind) begin
         rd_ptr_in = CntW'(best_idx_ff) + CntW'(1);
         pend_in   = 1'b0;
      end

      if (cmd.walk) begin
         pend_in = 1'b0;
         if (rd_ptr_ff != fill_ff) begin
            rd_en       = 1'b1;
            rd_ptr_in   = rd_ptr_ff + CntW'(1);
            pend_in     = 1'b1;
            pend_idx_in = rd_ptr_ff[IdxW-1:0];
         end
         if (pend_ff) begin
            if (cmd.shift) begin
               // move returned entry one slot down
               wr_en = 1'b1;
            end else begin
               if (rd_key == req_key_ff) begin
                  dup_in = 1'b1;
               end
               // strict less-than keeps the earliest of equal values
               if (pend_idx_ff == '0 || rd_value < best_value_ff) begin
                  best_idx_in   = pend_idx_ff;
                  best_key_in   = rd_key;
                  best_value_in = rd_value;
               end
            end
         end
      end

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         rsp_key_in   = '0;
         rsp_value_in = '0;
         if (req_kind_ff == ukt_pkg::KIND_INSERT) begin
            if (dup_ff) begin
               rsp_status_in = ukt_pkg::ST_DUPLICATE;
            end else if (fill_ff >= CntW'(CAPACITY)) begin
               rsp_status_in = ukt_pkg::ST_FULL;
            end else begin
               wr_en         = 1'b1;
               wr_addr       = fill_ff[IdxW-1:0];
               wr_data       = {req_key_ff, req_value_ff};
               fill_in       = fill_ff + CntW'(1);
               rsp_status_in = ukt_pkg::ST_INSERTED;
            end
         end else if (fill_ff == '0) begin
            rsp_status_in = ukt_pkg::ST_EMPTY;
         end else begin
            rsp_status_in = ukt_pkg::ST_REMOVED;
            rsp_key_in    = best_key_ff;
            rsp_value_in  = best_value_ff;
            fill_in       = fill_ff - CntW'(1);
         end
         rsp_total_in = ukt_pkg::TOTAL_W'(fill_in);
      end
   end

   // Entry store ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_ff[rd_addr];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload state
   always_ff @(posedge clock) begin
      rd_ptr_ff     <= rd_ptr_in;
      pend_idx_ff   <= pend_idx_in;
      dup_ff        <= dup_in;
      best_idx_ff   <= best_idx_in;
      best_key_ff   <= best_key_in;
      best_value_ff <= best_value_in;
      req_kind_ff   <= req_kind_in;
      req_key_ff    <= req_key_in;
      req_value_ff  <= req_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign stat.walk_done = (rd_ptr_ff == fill_ff) && !pend_ff;
   assign stat.empty     = (fill_ff == '0);
   assign stat.remove    = (req_kind_ff == ukt_pkg::KIND_REMOVE);

   assign rsp_strobe        = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_key   = rsp_key_ff;
   assign rsp_removed_value = rsp_value_ff;
   assign rsp_entry_total   = rsp_total_ff;

   // Checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CntW'(CAPACITY))
      else $error("fill count above capacity");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (CntW'(rd_addr) < fill_ff))
      else $error("read beyond held entries");

   a_removed_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ukt_pkg::ST_REMOVED)
         |-> (rsp_key_ff == '0 && rsp_value_ff == '0))
      else $error("removed fields nonzero without a removal");

endmodule
